// ===== sv/mlfc_pkg.sv =====
// Shared types, constants and reset values for the motion light fade controller.
package mlfc_pkg;

  localparam int SAMPLES_PER_TICK_DEF = 16;
  localparam int SAMPLE_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] HOLD_TICKS_RST = 16'd300;
  localparam logic [15:0] AMBIENT_INTERVAL_RST = 16'd100;
  localparam logic [7:0] DUTY_MAX_RST = 8'd200;
  localparam logic [7:0] DUTY_MIN_RST = 8'd30;
  localparam logic [3:0] VOTE_THRESHOLD_RST = 4'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HOLD_TICKS = 3'd0,
    REG_AMBIENT_INTERVAL = 3'd1,
    REG_DUTY_MAX = 3'd2,
    REG_DUTY_MIN = 3'd3,
    REG_VOTE_THRESHOLD = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_GLOW = 2'd1,
    MODE_LIGHT = 2'd2,
    MODE_FADE = 2'd3
  } mode_t;

  typedef struct packed {
    logic [15:0] motion_samples_a;
    logic [15:0] motion_samples_b;
    logic        ambient_bright;
  } in_word_t;

  typedef struct packed {
    logic [7:0] duty;
    logic       pwm_enabled;
    logic       daylight_led;
    logic [1:0] mode;
  } out_word_t;

  typedef struct packed {
    logic [15:0] hold_ticks;
    logic [15:0] ambient_interval;
    logic [7:0]  duty_max;
    logic [7:0]  duty_min;
    logic [3:0]  vote_threshold;
  } cfg_t;

endpackage

// ===== sv/mlfc_vote.sv =====
// Sample vote for one motion sensor: popcount of the counted samples against the threshold.
module mlfc_vote #(
  parameter int SAMPLES_PER_TICK = mlfc_pkg::SAMPLES_PER_TICK_DEF
) (
  input  logic [mlfc_pkg::SAMPLE_W-1:0] samples,
  input  logic [3:0]                    threshold,
  output logic                          active
);
  import mlfc_pkg::*;

  localparam int NB = (SAMPLES_PER_TICK < SAMPLE_W) ? SAMPLES_PER_TICK : SAMPLE_W;
  localparam logic [SAMPLE_W:0] MASK_WIDE = (17'd1 << NB) - 17'd1;
  localparam logic [SAMPLE_W-1:0] MASK = MASK_WIDE[SAMPLE_W-1:0];

  logic [15:0] x0, x1, x2, x3;
  logic [4:0]  count;

  // SWAR popcount: pairs, nibbles, bytes, halves
  always_comb begin
    x0 = samples & MASK;
    x1 = (x0 & 16'h5555) + ((x0 >> 1) & 16'h5555);
    x2 = (x1 & 16'h3333) + ((x1 >> 2) & 16'h3333);
    x3 = (x2 & 16'h0F0F) + ((x2 >> 4) & 16'h0F0F);
    count = x3[4:0] + x3[12:8];
    active = count > {1'b0, threshold};
  end

endmodule

// ===== sv/mlfc_core.sv =====
// Per-tick mode update; the state registers double as the result word.
module mlfc_core #(
  parameter int SAMPLES_PER_TICK = mlfc_pkg::SAMPLES_PER_TICK_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  mlfc_pkg::in_word_t word,
  input  mlfc_pkg::cfg_t     cfg,
  output mlfc_pkg::out_word_t result
);
  import mlfc_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic        bright_r, bright_nxt;
  logic        phase_r, phase_nxt;
  logic [7:0]  duty_r, duty_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [15:0] amb_cnt_r, amb_cnt_nxt;
  logic        pwm_r, pwm_nxt;

  logic act_a, act_b, motion, amb_hit;
  logic [7:0]  duty_inc;
  logic [15:0] hold_inc;

  mlfc_vote #(.SAMPLES_PER_TICK(SAMPLES_PER_TICK)) u_vote_a (
    .samples(word.motion_samples_a), .threshold(cfg.vote_threshold), .active(act_a)
  );
  mlfc_vote #(.SAMPLES_PER_TICK(SAMPLES_PER_TICK)) u_vote_b (
    .samples(word.motion_samples_b), .threshold(cfg.vote_threshold), .active(act_b)
  );

  always_comb begin
    motion = act_a | act_b;
    amb_hit = amb_cnt_r > cfg.ambient_interval;
    bright_nxt = amb_hit ? word.ambient_bright : bright_r;
    mode_nxt = mode_r;
    phase_nxt = phase_r;
    duty_nxt = duty_r;
    hold_nxt = hold_r;
    pwm_nxt = pwm_r;
    duty_inc = duty_r + 8'd1;
    hold_inc = hold_r + 16'd1;
    case (mode_r)
      MODE_IDLE: begin
        if (!bright_nxt && motion) begin
          mode_nxt = MODE_GLOW;
          pwm_nxt = 1'b1;
          duty_nxt = cfg.duty_min;
        end
      end
      MODE_GLOW: begin
        duty_nxt = duty_inc;
        if (duty_inc >= cfg.duty_max) begin
          duty_nxt = cfg.duty_max;
          mode_nxt = MODE_LIGHT;
          hold_nxt = '0;
        end
      end
      MODE_LIGHT: begin
        hold_nxt = motion ? 16'd0 : hold_inc;
        if (bright_nxt || (hold_nxt > cfg.hold_ticks)) mode_nxt = MODE_FADE;
      end
      default: begin
        if (phase_r) begin
          duty_nxt = duty_r - 8'd1;
          phase_nxt = 1'b0;
        end else begin
          phase_nxt = 1'b1;
          if (!bright_nxt && motion) mode_nxt = MODE_GLOW;
        end
        // switch-off wins over a re-glow in the same tick
        if (duty_nxt < cfg.duty_min) begin
          pwm_nxt = 1'b0;
          mode_nxt = MODE_IDLE;
        end
      end
    endcase
    amb_cnt_nxt = (amb_hit ? 16'd0 : amb_cnt_r) + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      bright_r <= 1'b0;
      phase_r <= 1'b1;
      duty_r <= '0;
      hold_r <= '0;
      amb_cnt_r <= '0;
      pwm_r <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      bright_r <= bright_nxt;
      phase_r <= phase_nxt;
      duty_r <= duty_nxt;
      hold_r <= hold_nxt;
      amb_cnt_r <= amb_cnt_nxt;
      pwm_r <= pwm_nxt;
    end
  end

  assign result.duty = duty_r;
  assign result.pwm_enabled = pwm_r;
  assign result.daylight_led = bright_r;
  assign result.mode = mode_r;

endmodule

// ===== sv/motion_light_fade_controller.sv =====
// Motion light fade controller: input register, tick update, result register, config registers.
// An accepted word waits in the input register until the result register is empty or not
// stalled; then the tick update writes its result into the state registers.
// Throughput: one word per cycle while out_stall is low; the tick update is a single pass
// between the input register and the state registers, which also hold the result word.
// Reset (synchronous, rst_n low): idle mode, duty 0, PWM off, fade phase set,
// counters cleared, configuration back to its defaults, both channels empty.
module motion_light_fade_controller #(
  parameter int SAMPLES_PER_TICK = mlfc_pkg::SAMPLES_PER_TICK_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  mlfc_pkg::in_word_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output mlfc_pkg::out_word_t                 out_data,
  input  logic                                cfg_we,
  input  logic [mlfc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mlfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mlfc_pkg::*;

  in_word_t in_data_r;
  logic     in_valid_r, in_valid_nxt;
  logic     out_valid_r, out_valid_nxt;
  cfg_t     cfg_r;
  logic     advance, take_in;

  assign advance = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign take_in = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = take_in ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && !out_stall ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) in_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hold_ticks <= HOLD_TICKS_RST;
      cfg_r.ambient_interval <= AMBIENT_INTERVAL_RST;
      cfg_r.duty_max <= DUTY_MAX_RST;
      cfg_r.duty_min <= DUTY_MIN_RST;
      cfg_r.vote_threshold <= VOTE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HOLD_TICKS:       cfg_r.hold_ticks <= cfg_wdata;
        REG_AMBIENT_INTERVAL: cfg_r.ambient_interval <= cfg_wdata;
        REG_DUTY_MAX:         cfg_r.duty_max <= cfg_wdata[7:0];
        REG_DUTY_MIN:         cfg_r.duty_min <= cfg_wdata[7:0];
        REG_VOTE_THRESHOLD:   cfg_r.vote_threshold <= cfg_wdata[3:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  mlfc_core #(.SAMPLES_PER_TICK(SAMPLES_PER_TICK)) u_core (
    .clk(clk),
    .rst_n(rst_n),
    .step(advance),
    .word(in_data_r),
    .cfg(cfg_r),
    .result(out_data)
  );

  assign out_valid = out_valid_r;

endmodule

// ===== sv/mlfc_checker.sv =====
// Port-level checks for the motion light fade controller, bound to the top level.
module mlfc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input mlfc_pkg::out_word_t out_data
);
  import mlfc_pkg::*;

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // PWM runs exactly when the mode is not idle
  a_pwm_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.mode == MODE_IDLE) == !out_data.pwm_enabled))
    else $error("pwm enable disagrees with mode");

endmodule

bind motion_light_fade_controller mlfc_checker u_mlfc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data(out_data)
);

// ===== bench/mlfc_tb_pkg.sv =====
// Scoreboard for the motion light fade controller bench: tick predictor and result check.
package mlfc_tb_pkg;
  import mlfc_pkg::*;

  class fade_scoreboard;
    logic [15:0] hold_ticks;
    logic [15:0] ambient_interval;
    logic [7:0]  duty_max;
    logic [7:0]  duty_min;
    logic [3:0]  vote_threshold;

    mode_t       mode;
    logic        bright;
    logic        fade_phase;
    logic [7:0]  duty;
    logic [15:0] hold_count;
    logic [15:0] ambient_count;
    logic        pwm_on;
    logic        indicator;

    out_word_t   expected_words[$];
    int          mismatches;

    function new();
      hold_ticks       = HOLD_TICKS_RST;
      ambient_interval = AMBIENT_INTERVAL_RST;
      duty_max         = DUTY_MAX_RST;
      duty_min         = DUTY_MIN_RST;
      vote_threshold   = VOTE_THRESHOLD_RST;
      mode             = MODE_IDLE;
      bright           = 1'b0;
      fade_phase       = 1'b1;
      duty             = 8'd0;
      hold_count       = 16'd0;
      ambient_count    = 16'd0;
      pwm_on           = 1'b0;
      indicator        = 1'b0;
      mismatches       = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] val);
      case (idx)
        REG_HOLD_TICKS:       hold_ticks = val;
        REG_AMBIENT_INTERVAL: ambient_interval = val;
        REG_DUTY_MAX:         duty_max = val[7:0];
        REG_DUTY_MIN:         duty_min = val[7:0];
        REG_VOTE_THRESHOLD:   vote_threshold = val[3:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Advance one tick and queue the word it shows.
    function void note_tick(in_word_t w);
      logic      motion;
      out_word_t want;
      motion = ($countones(w.motion_samples_a) > int'(vote_threshold)) ||
               ($countones(w.motion_samples_b) > int'(vote_threshold));

      if (ambient_count > ambient_interval) begin
        ambient_count = 16'd0;
        bright        = w.ambient_bright;
        indicator     = w.ambient_bright;
      end

      case (mode)
        MODE_IDLE: begin
          if (!bright && motion) begin
            mode   = MODE_GLOW;
            pwm_on = 1'b1;
            duty   = duty_min;
          end
        end
        MODE_GLOW: begin
          // wraps past 255 to zero when the glow starts from a floor of 255
          duty = duty + 8'd1;
          if (duty >= duty_max) begin
            duty       = duty_max;
            mode       = MODE_LIGHT;
            hold_count = 16'd0;
          end
        end
        MODE_LIGHT: begin
          hold_count = hold_count + 16'd1;
          if (motion) hold_count = 16'd0;
          if (bright) mode = MODE_FADE;
          if (hold_count > hold_ticks) mode = MODE_FADE;
        end
        default: begin
          if (fade_phase) begin
            duty       = duty - 8'd1;
            fade_phase = 1'b0;
          end else begin
            fade_phase = 1'b1;
            if (!bright && motion) mode = MODE_GLOW;
          end
          // switch-off wins over a re-glow in the same tick
          if (duty < duty_min) begin
            pwm_on = 1'b0;
            mode   = MODE_IDLE;
          end
        end
      endcase

      ambient_count = ambient_count + 16'd1;

      want.duty         = duty;
      want.pwm_enabled  = pwm_on;
      want.daylight_led = indicator;
      want.mode         = mode;
      expected_words.push_back(want);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        $error("result word %h with no tick pending", got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.duty !== want.duty) begin
        $error("duty: expected %0d, got %0d", want.duty, got.duty);
        mismatches++;
      end
      if (got.pwm_enabled !== want.pwm_enabled) begin
        $error("pwm_enabled: expected %0d, got %0d", want.pwm_enabled, got.pwm_enabled);
        mismatches++;
      end
      if (got.daylight_led !== want.daylight_led) begin
        $error("daylight_led: expected %0d, got %0d", want.daylight_led, got.daylight_led);
        mismatches++;
      end
      if (got.mode !== want.mode) begin
        $error("mode: expected %0d, got %0d", want.mode, got.mode);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== bench/motion_light_fade_controller_tb.sv =====
// Bench top for the motion light fade controller: drives ticks and config, checks each result word.
module motion_light_fade_controller_tb;
  import mlfc_pkg::*;
  import mlfc_tb_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fade_scoreboard sb;
  bit             tx_calm;
  bit             rx_calm;
  bit             rx_hold_req;
  logic           amb_level;
  int             rx_gap;

  motion_light_fade_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] samples_with(int k);
    logic [15:0] s;
    s = '0;
    while ($countones(s) < k) s[4'($urandom_range(0, 15))] = 1'b1;
    return s;
  endfunction

  task automatic send_tick(input in_word_t w);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(w);
  endtask

  // Drop valid and wait until every queued word has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic set_config(input logic [15:0] hold, input logic [15:0] interval,
                            input logic [7:0] dmax, input logic [7:0] dmin,
                            input logic [3:0] thr);
    settle();
    write_cfg(REG_HOLD_TICKS, hold);
    write_cfg(REG_AMBIENT_INTERVAL, interval);
    write_cfg(REG_DUTY_MAX, {8'd0, dmax});
    write_cfg(REG_DUTY_MIN, {8'd0, dmin});
    write_cfg(REG_VOTE_THRESHOLD, {12'd0, thr});
    cfg_we <= 1'b0;
  endtask

  task automatic directed_ticks();
    set_config(16'd2, 16'd0, 8'd34, 8'd30, 4'd10);
    send_tick({16'hFFFF, 16'h0000, 1'b0});
    send_tick({16'h0000, 16'hFFFF, 1'b0});
    send_tick({16'h0000, 16'h0000, 1'b0});
    send_tick({16'h07FF, 16'h0000, 1'b0});
    send_tick({16'h0000, 16'h0000, 1'b0});
    send_tick({16'h03FF, 16'h03FF, 1'b0});
    send_tick({16'h0000, 16'h0000, 1'b0});
    send_tick({16'h0000, 16'h0000, 1'b0});
    send_tick({16'h0000, 16'h0000, 1'b0});
    send_tick({16'hFFFF, 16'hFFFF, 1'b0});
    send_tick({16'h0000, 16'h0000, 1'b0});
    send_tick({16'hFFFF, 16'h0000, 1'b1});
    send_tick({16'hFFFF, 16'hFFFF, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'hFFFF, 16'hFFFF, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b1});
    send_tick({16'h0000, 16'h0000, 1'b0});
    send_tick({16'hFFFF, 16'hFFFF, 1'b0});
  endtask

  task automatic run_phase(input logic [15:0] hold, input logic [15:0] interval,
                           input logic [7:0] dmax, input logic [7:0] dmin,
                           input logic [3:0] thr, input int n, input int motion_pct,
                           input int flip_pct, input bit calm, input bit pressure);
    in_word_t w;
    int       ka;
    int       kb;
    int       t;
    set_config(hold, interval, dmax, dmin, thr);
    tx_calm     = calm || pressure;
    rx_calm     = calm;
    rx_hold_req = pressure;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < flip_pct) amb_level = ~amb_level;
      if ($urandom_range(0, 9) == 0) begin
        w.motion_samples_a = 16'($urandom_range(0, 65535));
        w.motion_samples_b = 16'($urandom_range(0, 65535));
        w.ambient_bright   = 1'($urandom_range(0, 1));
      end else begin
        if (thr != 4'd15 && $urandom_range(0, 99) < motion_pct) begin
          ka = $urandom_range(int'(thr) + 1, 16);
          kb = $urandom_range(0, 16);
          if ($urandom_range(0, 1)) begin
            t  = ka;
            ka = kb;
            kb = t;
          end
        end else begin
          ka = $urandom_range(0, int'(thr));
          kb = $urandom_range(0, int'(thr));
        end
        w.motion_samples_a = samples_with(ka);
        w.motion_samples_b = samples_with(kb);
        w.ambient_bright   = amb_level;
      end
      send_tick(w);
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin
    sb = new();
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_we      <= 1'b0;
    cfg_addr    <= '0;
    cfg_wdata   <= '0;
    rst_n       <= 1'b0;
    tx_calm     = 1'b0;
    rx_calm     = 1'b0;
    rx_hold_req = 1'b0;
    amb_level   = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_ticks();
    run_phase(16'd20,    16'd3,     8'd200, 8'd30,  4'd10, 250, 40, 4, 1'b0, 1'b0);
    run_phase(16'd0,     16'd0,     8'd255, 8'd1,   4'd0,  200, 50, 6, 1'b1, 1'b0);
    // floor above ceiling: glow clamps straight to the ceiling, fade ends at once
    run_phase(16'd5,     16'd1,     8'd5,   8'd250, 4'd7,  150, 50, 5, 1'b0, 1'b0);
    run_phase(16'd65534, 16'd65534, 8'd1,   8'd255, 4'd3,  150, 40, 3, 1'b0, 1'b0);
    run_phase(16'd10,    16'd2,     8'd255, 8'd255, 4'd15, 80,  50, 5, 1'b0, 1'b0);
    run_phase(16'd300,   16'd100,   8'd200, 8'd30,  4'd10, 300, 30, 2, 1'b0, 1'b0);
    run_phase(16'd8,     16'd5,     8'd60,  8'd20,  4'd12, 270, 40, 4, 1'b0, 1'b1);
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("[motion_light_fade_controller] OK");
    else
      $display("[motion_light_fade_controller] ERROR");
    $finish;
  end

  // Result side: check each word, then stall for a drawn gap, or a set one on a hold request.
  initial begin
    out_stall <= 1'b0;
    rx_gap = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_word(out_data);
        rx_gap = rx_calm ? 0 : $urandom_range(0, 5);
        if (rx_hold_req) begin
          rx_gap      = 60;
          rx_hold_req = 1'b0;
        end
      end else if (rx_gap > 0) begin
        rx_gap--;
      end
      out_stall <= (rx_gap > 0);
    end
  end

  initial begin
    #3000000;
    $display("[motion_light_fade_controller] ERROR");
    $finish;
  end

endmodule
